FILE: design/assert_macros.svh
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk, off during rst.
`define ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");

`endif

FILE: design/pdhf_pkg.sv
// Package: constants, types and the angle table of the pose deviation pipeline.
`timescale 1ns / 1ps
`default_nettype none
package pdhf_pkg;
  localparam int CORDIC_STAGES = 16;
  localparam int TAB_LEN = 30;
  localparam int NSTG = (CORDIC_STAGES > TAB_LEN) ? TAB_LEN : CORDIC_STAGES;
  localparam int VW = 40;
  localparam int RW = 34;
  localparam int LATENCY = 2 * NSTG + 7;
  localparam logic signed [RW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [RW-1:0] ONE_Q30 = 34'sd1073741824;
  localparam logic signed [31:0] PI_Q29 = 32'sd1686629713;
  localparam logic signed [33:0] GIMBAL_LIM = 34'sd1073731087;

  typedef enum logic [1:0] {
    MODE_PLAIN,
    MODE_NEG2,
    MODE_POS2
  } yaw_mode_t;

  function automatic logic [31:0] atan_at(input int i);
    logic [31:0] t [TAB_LEN];
    t = '{32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
          32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
          32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
          32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
          32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
          32'd20, 32'd10, 32'd5, 32'd3, 32'd1};
    return t[5'(i)];
  endfunction
endpackage
`default_nettype wire

FILE: design/pose_deviation_in_heading_frame.sv
// Top level: pose deviation of a target pose in the heading frame of a base pose.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// A pose pair is taken on every cycle that start is high; busy stays low, so the
// block accepts one pair per clock. Each result passes two 16-stage CORDIC
// pipelines, vectoring for both yaws and then rotation for the base heading,
// plus seven stages of products, setup, clamping, multiplication and rounding,
// and is shown for one cycle with done high. The receiver cannot stall, so a
// result must be taken in the cycle it is shown.
module pose_deviation_in_heading_frame (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] base_x,
  input  wire logic signed [31:0] base_y,
  input  wire logic signed [15:0] base_qx,
  input  wire logic signed [15:0] base_qy,
  input  wire logic signed [15:0] base_qz,
  input  wire logic signed [15:0] base_qw,
  input  wire logic signed [31:0] target_x,
  input  wire logic signed [31:0] target_y,
  input  wire logic signed [15:0] target_qx,
  input  wire logic signed [15:0] target_qy,
  input  wire logic signed [15:0] target_qz,
  input  wire logic signed [15:0] target_qw,
  output logic                    done,
  output logic signed [31:0]      lateral_dev,
  output logic signed [31:0]      longitudinal_dev,
  output logic signed [15:0]      yaw_dev
);
  localparam int N = pdhf_pkg::NSTG;
  localparam int VW = pdhf_pkg::VW;
  localparam int RW = pdhf_pkg::RW;

  logic signed [15:0] qix [2];
  logic signed [15:0] qiy [2];
  logic signed [15:0] qiz [2];
  logic signed [15:0] qiw [2];

  // stage 1: products
  logic               v1;
  logic signed [31:0] m_xz [2];
  logic signed [31:0] m_wy [2];
  logic signed [31:0] m_xy [2];
  logic signed [31:0] m_wz [2];
  logic signed [31:0] m_ww [2];
  logic signed [31:0] m_xx [2];
  logic signed [31:0] m_yy [2];
  logic signed [31:0] m_zz [2];
  logic signed [15:0] r_qx [2];
  logic signed [15:0] r_qy [2];
  logic signed [32:0] dx1;
  logic signed [32:0] dy1;

  // stage 2: branch selection
  logic                   v2;
  logic signed [VW-1:0]   ax2 [2];
  logic signed [VW-1:0]   ay2 [2];
  pdhf_pkg::yaw_mode_t    md2 [2];
  logic signed [32:0]     dx2;
  logic signed [32:0]     dy2;

  // vectoring pipeline
  logic                   vv [N+1];
  logic signed [VW-1:0]   vx [N+1][2];
  logic signed [VW-1:0]   vy [N+1][2];
  logic [31:0]            vz [N+1][2];
  pdhf_pkg::yaw_mode_t    vmd [N+1][2];
  logic signed [32:0]     vdx [N+1];
  logic signed [32:0]     vdy [N+1];

  // rotation pipeline
  logic                   rv [N+1];
  logic signed [RW-1:0]   rx [N+1];
  logic signed [RW-1:0]   ry [N+1];
  logic signed [RW-1:0]   rz [N+1];
  logic signed [31:0]     rd [N+1];
  logic signed [32:0]     rdx [N+1];
  logic signed [32:0]     rdy [N+1];

  // clamp, multiply, round
  logic                   vc;
  logic signed [31:0]     cc;
  logic signed [31:0]     sc;
  logic signed [31:0]     dc;
  logic signed [32:0]     dxc;
  logic signed [32:0]     dyc;
  logic                   vm;
  logic signed [50:0]     p_cdy;
  logic signed [50:0]     p_sdx;
  logic signed [50:0]     p_cdx;
  logic signed [50:0]     p_sdy;
  logic signed [63:0]     p_yaw;

  logic signed [51:0]     lat_sum;
  logic signed [51:0]     lon_sum;
  logic signed [35:0]     lat_r;
  logic signed [35:0]     lon_r;
  logic signed [63:0]     yaw_r;
  logic signed [31:0]     lat_next;
  logic signed [31:0]     lon_next;
  logic signed [15:0]     yaw_next;

  assign busy = 1'b0;
  assign qix = '{base_qx, target_qx};
  assign qiy = '{base_qy, target_qy};
  assign qiz = '{base_qz, target_qz};
  assign qiw = '{base_qw, target_qw};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start;
    end
    for (int q = 0; q < 2; q++) begin
      m_xz[q] <= qix[q] * qiz[q];
      m_wy[q] <= qiw[q] * qiy[q];
      m_xy[q] <= qix[q] * qiy[q];
      m_wz[q] <= qiw[q] * qiz[q];
      m_ww[q] <= qiw[q] * qiw[q];
      m_xx[q] <= qix[q] * qix[q];
      m_yy[q] <= qiy[q] * qiy[q];
      m_zz[q] <= qiz[q] * qiz[q];
      r_qx[q] <= qix[q];
      r_qy[q] <= qiy[q];
    end
    dx1 <= 33'(target_x) - 33'(base_x);
    dy1 <= 33'(target_y) - 33'(base_y);
  end

  always_ff @(posedge clk) begin
    logic signed [33:0] sarg;
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    for (int q = 0; q < 2; q++) begin
      sarg = -((34'(m_xz[q]) - 34'(m_wy[q])) <<< 1);
      if (sarg <= -pdhf_pkg::GIMBAL_LIM) begin
        md2[q] <= pdhf_pkg::MODE_NEG2;
        ay2[q] <= VW'(r_qy[q]) <<< 14;
        ax2[q] <= VW'(r_qx[q]) <<< 14;
      end else if (sarg >= pdhf_pkg::GIMBAL_LIM) begin
        md2[q] <= pdhf_pkg::MODE_POS2;
        ay2[q] <= -(VW'(r_qy[q]) <<< 14);
        ax2[q] <= VW'(r_qx[q]) <<< 14;
      end else begin
        md2[q] <= pdhf_pkg::MODE_PLAIN;
        ay2[q] <= (VW'(m_xy[q]) + VW'(m_wz[q])) <<< 1;
        ax2[q] <= VW'(m_ww[q]) + VW'(m_xx[q]) - VW'(m_yy[q]) - VW'(m_zz[q]);
      end
    end
    dx2 <= dx1;
    dy2 <= dy1;
  end

  // stage 3: fold the left half plane, flag the zero vector with a zero angle
  always_ff @(posedge clk) begin
    if (rst) begin
      vv[0] <= 1'b0;
    end else begin
      vv[0] <= v2;
    end
    for (int q = 0; q < 2; q++) begin
      vmd[0][q] <= md2[q];
      if (ax2[q] < 0) begin
        vx[0][q] <= -ax2[q];
        vy[0][q] <= -ay2[q];
        vz[0][q] <= 32'h8000_0000;
      end else begin
        vx[0][q] <= ax2[q];
        vy[0][q] <= ay2[q];
        vz[0][q] <= 32'h0;
      end
    end
    vdx[0] <= dx2;
    vdy[0] <= dy2;
  end

  for (genvar i = 0; i < N; i++) begin : g_vec
    always_ff @(posedge clk) begin
      if (rst) begin
        vv[i+1] <= 1'b0;
      end else begin
        vv[i+1] <= vv[i];
      end
      for (int q = 0; q < 2; q++) begin
        vmd[i+1][q] <= vmd[i][q];
        if (vx[i][q] == 0 && vy[i][q] == 0) begin
          vx[i+1][q] <= vx[i][q];
          vy[i+1][q] <= vy[i][q];
          vz[i+1][q] <= 32'h0;
        end else if (vy[i][q] >= 0) begin
          vx[i+1][q] <= vx[i][q] + (vy[i][q] >>> i);
          vy[i+1][q] <= vy[i][q] - (vx[i][q] >>> i);
          vz[i+1][q] <= vz[i][q] + pdhf_pkg::atan_at(i);
        end else begin
          vx[i+1][q] <= vx[i][q] - (vy[i][q] >>> i);
          vy[i+1][q] <= vy[i][q] + (vx[i][q] >>> i);
          vz[i+1][q] <= vz[i][q] - pdhf_pkg::atan_at(i);
        end
      end
      vdx[i+1] <= vdx[i];
      vdy[i+1] <= vdy[i];
    end
  end

  // yaw from the vector angle, then fold the base heading into [-pi/2, pi/2]
  always_ff @(posedge clk) begin
    logic [31:0] yw [2];
    logic signed [RW-1:0] za;
    if (rst) begin
      rv[0] <= 1'b0;
    end else begin
      rv[0] <= vv[N];
    end
    for (int q = 0; q < 2; q++) begin
      case (vmd[N][q])
        pdhf_pkg::MODE_NEG2: yw[q] = 32'h0 - (vz[N][q] << 1);
        pdhf_pkg::MODE_POS2: yw[q] = vz[N][q] << 1;
        default:             yw[q] = vz[N][q];
      endcase
    end
    za = RW'($signed(yw[0]));
    if (za > pdhf_pkg::ONE_Q30 || za < -pdhf_pkg::ONE_Q30) begin
      rz[0] <= RW'($signed(yw[0] + 32'h8000_0000));
      rx[0] <= -pdhf_pkg::CORDIC_GAIN;
    end else begin
      rz[0] <= za;
      rx[0] <= pdhf_pkg::CORDIC_GAIN;
    end
    ry[0] <= '0;
    rd[0] <= $signed(yw[1] - yw[0]);
    rdx[0] <= vdx[N];
    rdy[0] <= vdy[N];
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    always_ff @(posedge clk) begin
      if (rst) begin
        rv[i+1] <= 1'b0;
      end else begin
        rv[i+1] <= rv[i];
      end
      if (rz[i] >= 0) begin
        rx[i+1] <= rx[i] - (ry[i] >>> i);
        ry[i+1] <= ry[i] + (rx[i] >>> i);
        rz[i+1] <= rz[i] - RW'(pdhf_pkg::atan_at(i));
      end else begin
        rx[i+1] <= rx[i] + (ry[i] >>> i);
        ry[i+1] <= ry[i] - (rx[i] >>> i);
        rz[i+1] <= rz[i] + RW'(pdhf_pkg::atan_at(i));
      end
      rd[i+1] <= rd[i];
      rdx[i+1] <= rdx[i];
      rdy[i+1] <= rdy[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
      vm <= 1'b0;
      done <= 1'b0;
    end else begin
      vc <= rv[N];
      vm <= vc;
      done <= vm;
    end
    if (rx[N] > pdhf_pkg::ONE_Q30) begin
      cc <= 32'(pdhf_pkg::ONE_Q30);
    end else if (rx[N] < -pdhf_pkg::ONE_Q30) begin
      cc <= 32'(-pdhf_pkg::ONE_Q30);
    end else begin
      cc <= 32'(rx[N]);
    end
    if (ry[N] > pdhf_pkg::ONE_Q30) begin
      sc <= 32'(pdhf_pkg::ONE_Q30);
    end else if (ry[N] < -pdhf_pkg::ONE_Q30) begin
      sc <= 32'(-pdhf_pkg::ONE_Q30);
    end else begin
      sc <= 32'(ry[N]);
    end
    dc <= rd[N];
    dxc <= rdx[N];
    dyc <= rdy[N];
    p_cdy <= 51'((65'(cc) * 65'(dyc)) >>> 14);
    p_sdx <= 51'((65'(sc) * 65'(dxc)) >>> 14);
    p_cdx <= 51'((65'(cc) * 65'(dxc)) >>> 14);
    p_sdy <= 51'((65'(sc) * 65'(dyc)) >>> 14);
    p_yaw <= 64'(dc) * 64'(pdhf_pkg::PI_Q29);
    lateral_dev <= lat_next;
    longitudinal_dev <= lon_next;
    yaw_dev <= yaw_next;
  end

  always_comb begin
    lat_sum = 52'(p_cdy) - 52'(p_sdx);
    lon_sum = 52'(p_cdx) + 52'(p_sdy);
    lat_r = 36'((lat_sum + 52'sd32768) >>> 16);
    lon_r = 36'((lon_sum + 52'sd32768) >>> 16);
    yaw_r = (p_yaw + (64'sd1 <<< 46)) >>> 47;
    if (lat_r > 36'sd2147483647) begin
      lat_next = 32'sh7FFF_FFFF;
    end else if (lat_r < -36'sd2147483648) begin
      lat_next = 32'sh8000_0000;
    end else begin
      lat_next = 32'(lat_r);
    end
    if (lon_r > 36'sd2147483647) begin
      lon_next = 32'sh7FFF_FFFF;
    end else if (lon_r < -36'sd2147483648) begin
      lon_next = 32'sh8000_0000;
    end else begin
      lon_next = 32'(lon_r);
    end
    if (yaw_r > 64'sd25735) begin
      yaw_next = 16'sd25735;
    end else if (yaw_r < -64'sd25736) begin
      yaw_next = -16'sd25736;
    end else begin
      yaw_next = 16'(yaw_r);
    end
  end

  `ASSERT_IMPL(a_vec_right_half, vv[0], vx[0][0] >= 0 && vx[0][1] >= 0)
  `ASSERT_IMPL(a_rot_folded, rv[0], rz[0] <= pdhf_pkg::ONE_Q30 && rz[0] >= -pdhf_pkg::ONE_Q30)
  `ASSERT_NEXT(a_valid_flow, rv[N], vc)
  `ASSERT_IMPL(a_yaw_range, done, yaw_dev >= -16'sd25736 && yaw_dev <= 16'sd25735)

endmodule
`default_nettype wire
